FILE: hw/rtl/csf_pkg.sv
// ----------------------------------------------------------------------------
// Calligraphic stroke filter package
// Shared widths, fixed-point constants, types and helper functions.
// ----------------------------------------------------------------------------
package csf_pkg;

  // Fixed-point format of coordinates, velocity and offsets.
  localparam int FRAC_BITS = 20;
  localparam int W         = 25;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 24;

  localparam longint ONE_F  = longint'(1) << FRAC_BITS;
  localparam longint VMAX   = (longint'(1) << (W - 1)) - 1;
  localparam longint VMIN   = -(longint'(1) << (W - 1));
  localparam longint C04    = (4 * ONE_F + 50) / 100;
  localparam longint WMIN   = (ONE_F + 50000) / 100000;
  localparam longint EPS_R  = (ONE_F + 500000) / 1000000;
  localparam longint EPS    = (EPS_R < 1) ? 1 : EPS_R;
  localparam longint EPS_SQ = EPS * EPS;
  localparam longint AX_FIX = (6 * ONE_F + 5) / 10;
  localparam longint AY_FIX = (2 * ONE_F + 5) / 10;
  localparam longint KEEP_ONE = longint'(1) << 33;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MASS  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_DRAG  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_FIXED = CFG_IDX_W'(3);

  typedef enum logic {OP_PEN_DOWN = 1'b0, OP_MOVE = 1'b1} item_kind_t;

  typedef enum logic [1:0] {ALU_MUL, ALU_DIV, ALU_SQRT} alu_op_t;

  typedef struct packed {
    item_kind_t            kind;
    logic signed [W-1:0]   x;
    logic signed [W-1:0]   y;
  } item_t;

  typedef struct packed {
    logic [16:0] mass;
    logic [16:0] drag;
    logic [23:0] width;
    logic        fixed;
  } cfg_t;

  // Clamp a wide signed value to the coordinate range.
  function automatic logic signed [W-1:0] sat_w(input logic signed [63:0] v);
    if (v > VMAX) return W'(VMAX);
    if (v < VMIN) return W'(VMIN);
    return v[W-1:0];
  endfunction

  // Magnitude of a signed value.
  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // Give a magnitude its sign back.
  function automatic logic signed [63:0] with_sign(input logic neg, input logic [63:0] q);
    return neg ? -signed'(q) : signed'(q);
  endfunction

endpackage

FILE: hw/rtl/csf_item_if.sv
// ----------------------------------------------------------------------------
// Pointer sample channel
// Valid/ready channel that carries one pointer sample per request.
// ----------------------------------------------------------------------------
interface csf_item_if;
  logic                              valid;
  logic                              ready;
  logic                              op;
  logic signed [csf_pkg::W-1:0]      x_pos;
  logic signed [csf_pkg::W-1:0]      y_pos;

  modport source (output valid, op, x_pos, y_pos, input ready);
  modport sink   (input valid, op, x_pos, y_pos, output ready);
endinterface

FILE: hw/rtl/csf_result_if.sv
// ----------------------------------------------------------------------------
// Stroke quad channel
// Valid/ready channel that carries one stroke quad per request.
// ----------------------------------------------------------------------------
interface csf_result_if;
  logic                              valid;
  logic                              ready;
  logic                              drawn;
  logic signed [csf_pkg::W-1:0]      v0_x;
  logic signed [csf_pkg::W-1:0]      v0_y;
  logic signed [csf_pkg::W-1:0]      v1_x;
  logic signed [csf_pkg::W-1:0]      v1_y;
  logic signed [csf_pkg::W-1:0]      v2_x;
  logic signed [csf_pkg::W-1:0]      v2_y;
  logic signed [csf_pkg::W-1:0]      v3_x;
  logic signed [csf_pkg::W-1:0]      v3_y;

  modport source (output valid, drawn, v0_x, v0_y, v1_x, v1_y, v2_x, v2_y, v3_x, v3_y,
                  input ready);
  modport sink   (input valid, drawn, v0_x, v0_y, v1_x, v1_y, v2_x, v2_y, v3_x, v3_y,
                  output ready);
endinterface

FILE: hw/rtl/csf_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel that carries a register index and write data.
// ----------------------------------------------------------------------------
interface csf_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [csf_pkg::CFG_IDX_W-1:0]     index;
  logic [csf_pkg::CFG_DAT_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/csf_front.sv
// ----------------------------------------------------------------------------
// Front end
// Accepts pointer samples, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module csf_front (
  input  logic              clk,
  input  logic              rst,
  csf_item_if.sink          in_ch,
  output logic              q_valid,
  output csf_pkg::item_t    q_item,
  input  logic              q_ready
);
  import csf_pkg::*;

  item_t       entry [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        push;
  logic        pop;
  item_t       classified;

  // Classify the incoming request.
  always_comb begin
    classified.kind = in_ch.op ? OP_MOVE : OP_PEN_DOWN;
    classified.x    = in_ch.x_pos;
    classified.y    = in_ch.y_pos;
  end

  assign in_ch.ready = (count != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (count != 2'd0);
  assign pop         = q_valid && q_ready;
  assign q_item      = entry[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= classified;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule

FILE: hw/rtl/csf_alu.sv
// ----------------------------------------------------------------------------
// Shared arithmetic unit
// Bit-serial multiply, restoring divide and integer square root.
// ----------------------------------------------------------------------------
module csf_alu (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  csf_pkg::alu_op_t  op,
  input  logic [63:0]       a,
  input  logic [63:0]       b,
  output logic              done,
  output logic [63:0]       res
);
  import csf_pkg::*;

  localparam int MUL_STEPS  = 34;
  localparam int DIV_STEPS  = 48;
  localparam int SQRT_STEPS = 26;
  localparam int SQRT_TOP   = 2 * (SQRT_STEPS - 1);

  alu_op_t     cur_op;
  logic        busy;
  logic [5:0]  cnt;
  logic [63:0] acc;
  logic [63:0] x;
  logic [63:0] y;
  logic [63:0] acc_next;
  logic [63:0] x_next;
  logic [63:0] y_next;
  logic [63:0] rem_sh;
  logic [63:0] trial;

  // One step of the selected operation.
  always_comb begin
    acc_next = acc;
    x_next   = x;
    y_next   = y;
    rem_sh   = {acc[62:0], x[DIV_STEPS-1]};
    trial    = x + y;
    case (cur_op)
      ALU_MUL: begin
        if (y[0]) acc_next = acc + x;
        x_next = {x[62:0], 1'b0};
        y_next = {1'b0, y[63:1]};
      end
      ALU_DIV: begin
        if (rem_sh >= y) begin
          acc_next = rem_sh - y;
          x_next   = {x[62:0], 1'b1};
        end else begin
          acc_next = rem_sh;
          x_next   = {x[62:0], 1'b0};
        end
      end
      ALU_SQRT: begin
        if (acc >= trial) begin
          acc_next = acc - trial;
          x_next   = {1'b0, x[63:1]} + y;
        end else begin
          x_next   = {1'b0, x[63:1]};
        end
        y_next = {2'b00, y[63:2]};
      end
      default: begin
        acc_next = acc;
      end
    endcase
  end

  // The quotient fills the low bits; dividend bits shifted above them are dropped.
  assign res = (cur_op == ALU_MUL) ? acc :
               (cur_op == ALU_DIV) ? {{(64 - DIV_STEPS){1'b0}}, x[DIV_STEPS-1:0]} : x;

  // Operand registers and step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
      cur_op <= ALU_MUL;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        cur_op <= op;
        case (op)
          ALU_MUL: begin
            acc <= '0;
            x   <= a;
            y   <= b;
            cnt <= 6'(MUL_STEPS);
          end
          ALU_DIV: begin
            acc <= '0;
            x   <= a;
            y   <= b;
            cnt <= 6'(DIV_STEPS);
          end
          default: begin
            acc <= a;
            x   <= '0;
            y   <= 64'd1 << SQRT_TOP;
            cnt <= 6'(SQRT_STEPS);
          end
        endcase
      end else if (busy) begin
        acc <= acc_next;
        x   <= x_next;
        y   <= y_next;
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

FILE: hw/rtl/csf_back.sv
// ----------------------------------------------------------------------------
// Back end
// Runs the mass and drag model for each queued sample and forms the quad.
// ----------------------------------------------------------------------------
module csf_back (
  input  logic              clk,
  input  logic              rst,
  input  csf_pkg::cfg_t     cfg,
  input  logic              q_valid,
  input  csf_pkg::item_t    q_item,
  output logic              q_ready,
  csf_result_if.source      out_ch
);
  import csf_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_SQ_FX, S_SQ_FY, S_ACC_X, S_ACC_Y, S_SQ_VX, S_SQ_VY, S_SQRT,
    S_NRM_X, S_NRM_Y, S_KEEP, S_DRAG_X, S_DRAG_Y, S_WID, S_OFF_X, S_OFF_Y, S_OUT
  } state_t;

  state_t                st;
  logic                  pend;
  logic signed [W-1:0]   pos_x, pos_y, vel_x, vel_y, prev_off_x, prev_off_y;
  logic signed [W:0]     fx, fy;
  logic [50:0]           t0;
  logic [25:0]           spd;
  logic signed [FRAC_BITS+1:0] ax, ay;
  logic [33:0]           keep;
  logic signed [W-1:0]   lx, ly, dx;
  logic [W-1:0]          wid;
  logic                  drawn;
  logic signed [W-1:0]   r0x, r0y, r1x, r1y, r2x, r2y, r3x, r3y;

  logic                  alu_start;
  alu_op_t               alu_op;
  logic [63:0]           alu_a, alu_b, alu_res;
  logic                  alu_done;
  logic [16:0]           ms_c, ds_c;
  logic [23:0]           den;
  logic                  wid_skip;
  logic [63:0]           sum_sq;
  logic [63:0]           rnd33, rnd16, rndf;
  logic signed [W-1:0]   vy_new, dy_new;

  csf_alu u_alu (
    .clk   (clk),
    .rst   (rst),
    .start (alu_start),
    .op    (alu_op),
    .a     (alu_a),
    .b     (alu_b),
    .done  (alu_done),
    .res   (alu_res)
  );

  // Settings above one act as one; mass denominator in Q8.16.
  assign ms_c     = (cfg.mass > 17'd65536) ? 17'd65536 : cfg.mass;
  assign ds_c     = (cfg.drag > 17'd65536) ? 17'd65536 : cfg.drag;
  assign den      = 24'(24'd65536 + 24'd159 * 24'(ms_c));
  assign wid_skip = (64'(spd) >= 64'(C04));

  // Operands for the shared unit.
  always_comb begin
    alu_op = ALU_MUL;
    alu_a  = '0;
    alu_b  = '0;
    case (st)
      S_SQ_FX:  begin alu_a = mag64(64'(fx)); alu_b = mag64(64'(fx)); end
      S_SQ_FY:  begin alu_a = mag64(64'(fy)); alu_b = mag64(64'(fy)); end
      S_ACC_X: begin
        alu_op = ALU_DIV;
        alu_a  = (mag64(64'(fx)) << 16) + 64'(den >> 1);
        alu_b  = 64'(den);
      end
      S_ACC_Y: begin
        alu_op = ALU_DIV;
        alu_a  = (mag64(64'(fy)) << 16) + 64'(den >> 1);
        alu_b  = 64'(den);
      end
      S_SQ_VX:  begin alu_a = mag64(64'(vel_x)); alu_b = mag64(64'(vel_x)); end
      S_SQ_VY:  begin alu_a = mag64(64'(vel_y)); alu_b = mag64(64'(vel_y)); end
      S_SQRT:   begin alu_op = ALU_SQRT; alu_a = 64'(t0); end
      S_NRM_X: begin
        alu_op = ALU_DIV;
        alu_a  = (mag64(64'(vel_y)) << FRAC_BITS) + 64'(spd >> 1);
        alu_b  = 64'(spd);
      end
      S_NRM_Y: begin
        alu_op = ALU_DIV;
        alu_a  = (mag64(64'(vel_x)) << FRAC_BITS) + 64'(spd >> 1);
        alu_b  = 64'(spd);
      end
      S_KEEP:   begin alu_a = 64'(ds_c); alu_b = 64'(ds_c); end
      S_DRAG_X: begin alu_a = 64'(keep); alu_b = mag64(64'(vel_x)); end
      S_DRAG_Y: begin alu_a = 64'(keep); alu_b = mag64(64'(vel_y)); end
      S_WID:    begin alu_a = 64'(C04) - 64'(spd); alu_b = 64'(cfg.width); end
      S_OFF_X:  begin alu_a = mag64(64'(ax)); alu_b = 64'(wid); end
      S_OFF_Y:  begin alu_a = mag64(64'(ay)); alu_b = 64'(wid); end
      default:  begin alu_op = ALU_MUL; end
    endcase
  end

  assign alu_start = (st != S_IDLE) && (st != S_OUT) && !pend &&
                     !((st == S_WID) && wid_skip);

  // Rounded results of the current unit output.
  assign sum_sq = 64'(t0) + alu_res;
  assign rnd33  = (alu_res + (64'd1 << 32)) >> 33;
  assign rnd16  = (alu_res + (64'd1 << 15)) >> 16;
  assign rndf   = (alu_res + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
  assign vy_new = sat_w(with_sign(vel_y < 0, rnd33));
  assign dy_new = sat_w(with_sign(ay < 0, rndf));

  assign q_ready      = (st == S_IDLE);
  assign out_ch.valid = (st == S_OUT);
  assign out_ch.drawn = drawn;
  assign out_ch.v0_x  = r0x;
  assign out_ch.v0_y  = r0y;
  assign out_ch.v1_x  = r1x;
  assign out_ch.v1_y  = r1y;
  assign out_ch.v2_x  = r2x;
  assign out_ch.v2_y  = r2y;
  assign out_ch.v3_x  = r3x;
  assign out_ch.v3_y  = r3y;

  // Sequencer, model state and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= S_IDLE;
      pend       <= 1'b0;
      pos_x      <= '0;
      pos_y      <= '0;
      vel_x      <= '0;
      vel_y      <= '0;
      prev_off_x <= '0;
      prev_off_y <= '0;
    end else begin
      if (alu_start) pend <= 1'b1;
      if (alu_done)  pend <= 1'b0;
      case (st)
        S_IDLE: begin
          if (q_valid) begin
            drawn <= 1'b0;
            {r0x, r0y, r1x, r1y, r2x, r2y, r3x, r3y} <= '0;
            if (q_item.kind == OP_PEN_DOWN) begin
              pos_x      <= q_item.x;
              pos_y      <= q_item.y;
              vel_x      <= '0;
              vel_y      <= '0;
              prev_off_x <= '0;
              prev_off_y <= '0;
              st         <= S_OUT;
            end else begin
              fx <= (W+1)'(q_item.x) - (W+1)'(pos_x);
              fy <= (W+1)'(q_item.y) - (W+1)'(pos_y);
              st <= S_SQ_FX;
            end
          end
        end
        S_SQ_FX: if (alu_done) begin
          t0 <= 51'(alu_res);
          st <= S_SQ_FY;
        end
        S_SQ_FY: if (alu_done) begin
          st <= (sum_sq < 64'(EPS_SQ)) ? S_OUT : S_ACC_X;
        end
        S_ACC_X: if (alu_done) begin
          vel_x <= sat_w(64'(vel_x) + with_sign(fx < 0, alu_res));
          st    <= S_ACC_Y;
        end
        S_ACC_Y: if (alu_done) begin
          vel_y <= sat_w(64'(vel_y) + with_sign(fy < 0, alu_res));
          st    <= S_SQ_VX;
        end
        S_SQ_VX: if (alu_done) begin
          t0 <= 51'(alu_res);
          st <= S_SQ_VY;
        end
        S_SQ_VY: if (alu_done) begin
          t0 <= 51'(sum_sq);
          st <= (sum_sq < 64'(EPS_SQ)) ? S_OUT : S_SQRT;
        end
        S_SQRT: if (alu_done) begin
          spd <= 26'(alu_res);
          if (cfg.fixed) begin
            ax <= (FRAC_BITS+2)'(AX_FIX);
            ay <= (FRAC_BITS+2)'(AY_FIX);
            st <= S_KEEP;
          end else begin
            st <= S_NRM_X;
          end
        end
        S_NRM_X: if (alu_done) begin
          ax <= (FRAC_BITS+2)'(with_sign(vel_y > 0, alu_res));
          st <= S_NRM_Y;
        end
        S_NRM_Y: if (alu_done) begin
          ay <= (FRAC_BITS+2)'(with_sign(vel_x < 0, alu_res));
          st <= S_KEEP;
        end
        S_KEEP: if (alu_done) begin
          keep <= 34'(64'(KEEP_ONE) - alu_res);
          st   <= S_DRAG_X;
        end
        S_DRAG_X: if (alu_done) begin
          vel_x <= sat_w(with_sign(vel_x < 0, rnd33));
          st    <= S_DRAG_Y;
        end
        S_DRAG_Y: if (alu_done) begin
          vel_y <= vy_new;
          lx    <= pos_x;
          ly    <= pos_y;
          pos_x <= sat_w(64'(pos_x) + 64'(vel_x));
          pos_y <= sat_w(64'(pos_y) + 64'(vy_new));
          st    <= S_WID;
        end
        S_WID: begin
          // Past the speed limit the nib collapses to its minimum width.
          if (wid_skip) begin
            wid <= W'(WMIN);
            st  <= S_OFF_X;
          end else if (alu_done) begin
            wid <= (rnd16 < 64'(WMIN)) ? W'(WMIN) : W'(rnd16);
            st  <= S_OFF_X;
          end
        end
        S_OFF_X: if (alu_done) begin
          dx <= sat_w(with_sign(ax < 0, rndf));
          st <= S_OFF_Y;
        end
        S_OFF_Y: if (alu_done) begin
          drawn      <= 1'b1;
          r0x        <= sat_w(64'(lx) + 64'(prev_off_x));
          r0y        <= sat_w(64'(ly) + 64'(prev_off_y));
          r1x        <= sat_w(64'(lx) - 64'(prev_off_x));
          r1y        <= sat_w(64'(ly) - 64'(prev_off_y));
          r2x        <= sat_w(64'(pos_x) - 64'(dx));
          r2y        <= sat_w(64'(pos_y) - 64'(dy_new));
          r3x        <= sat_w(64'(pos_x) + 64'(dx));
          r3y        <= sat_w(64'(pos_y) + 64'(dy_new));
          prev_off_x <= dx;
          prev_off_y <= dy_new;
          st         <= S_OUT;
        end
        S_OUT: if (out_ch.ready) begin
          st <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: hw/rtl/calligraphic_stroke_filter_core.sv
// ----------------------------------------------------------------------------
// Calligraphic stroke filter core
// Pointer samples in, one calligraphic stroke quad out per sample.
// ----------------------------------------------------------------------------
// Each sample yields exactly one result. A pen-down goes from the idle state
// straight to the output state. A move runs the most operations when the nib
// follows the velocity normal, fewer with the fixed nib direction, and fewer
// when the force or the speed is small or the speed is past the width
// limit. The time is set by the single bit-serial arithmetic unit that
// performs every multiply, divide and square root in turn. A two-entry queue
// in front lets two further samples be taken while a sample is in progress or
// its quad waits to be taken. Configuration writes are always accepted and
// must be made while idle.
module calligraphic_stroke_filter_core (
  input  logic          clk,
  input  logic          rst,
  csf_item_if.sink      in_ch,
  csf_result_if.source  out_ch,
  csf_cfg_if.sink       cfg_ch
);
  import csf_pkg::*;

  cfg_t   cfg;
  logic   q_valid;
  item_t  q_item;
  logic   q_ready;

  assign cfg_ch.ready = 1'b1;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mass  <= 17'd32768;
      cfg.drag  <= 17'd9830;
      cfg.width <= 24'd98304;
      cfg.fixed <= 1'b1;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_MASS:  cfg.mass  <= cfg_ch.data[16:0];
        CFG_DRAG:  cfg.drag  <= cfg_ch.data[16:0];
        CFG_WIDTH: cfg.width <= cfg_ch.data[23:0];
        CFG_FIXED: cfg.fixed <= cfg_ch.data[0];
        default:   cfg.fixed <= cfg.fixed;
      endcase
    end
  end

  csf_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_ready (q_ready)
  );

  csf_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_ready (q_ready),
    .out_ch  (out_ch)
  );
endmodule
